[hw/rtl/rzs_pkg.sv]
// Shared types and constants for the rolling z-score band classifier.
// No dependencies; every other file imports this package.
package rzs_pkg;

  localparam int unsigned SpreadW = 25;
  localparam int unsigned PriceW  = 24;
  localparam int unsigned SumW    = 31;
  localparam int unsigned SqSumW  = 56;
  localparam int unsigned NumW    = 33;
  localparam int unsigned ZW      = 20;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned AluW    = 64;
  localparam int unsigned MulW    = 32;
  localparam int unsigned RemW    = 62;
  localparam int unsigned QuoW    = 39;
  localparam int unsigned DvdW    = 86;
  localparam int unsigned FracBits = 24;
  localparam int unsigned SqrtTop = 18;
  localparam int unsigned CfgIdxW = 8;

  localparam logic signed [ZW-1:0] ZMax = 20'sh7FFFF;
  localparam logic signed [ZW-1:0] ZMin = 20'sh80000;
  localparam logic [ZW-1:0]        KCap = 20'h80000;

  localparam logic [CfgIdxW-1:0] RegHigh  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegInner = 8'd1;

  localparam logic [ThrW-1:0] HighReset  = 16'd4096;
  localparam logic [ThrW-1:0] InnerReset = 16'd3277;

  localparam logic [1:0] ClsHigh   = 2'd0;
  localparam logic [1:0] ClsLow    = 2'd1;
  localparam logic [1:0] ClsInside = 2'd2;
  localparam logic [1:0] ClsMid    = 2'd3;

  typedef struct packed {
    logic [MulW-1:0] mul_a;
    logic [MulW-1:0] mul_b;
    logic [AluW-1:0] sub_a;
    logic [AluW-1:0] sub_b;
  } alu_req_t;

  typedef struct packed {
    logic [AluW-1:0] prod;
    logic [AluW-1:0] diff;
    logic            borrow;
  } alu_rsp_t;

endpackage

[hw/rtl/rzs_alu.sv]
// Shared arithmetic unit: one 32x32 multiplier and one 64-bit subtractor.
// Depends on rzs_pkg.
module rzs_alu
  import rzs_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [AluW:0] sub_full;

  assign sub_full   = {1'b0, req.sub_a} - {1'b0, req.sub_b};
  assign rsp.prod   = AluW'(req.mul_a) * AluW'(req.mul_b);
  assign rsp.diff   = sub_full[AluW-1:0];
  assign rsp.borrow = sub_full[AluW];

endmodule

[hw/rtl/rzs_ring.sv]
// Spread ring memory: one write port, one registered read port.
// Depends on rzs_pkg.
module rzs_ring
  import rzs_pkg::*;
#(
  parameter int unsigned Depth = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [SpreadW-1:0]       wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [SpreadW-1:0]       rd_data
);

  logic [SpreadW-1:0] mem [Depth];
  logic [SpreadW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/rolling_zscore_band_classifier_core.sv]
// Rolling z-score band classifier, top level. Depends on rzs_pkg, rzs_alu, rzs_ring.
// Until WINDOW spreads are held an item only squares its spread; then it runs 5 set-up
// steps, 86 division and 19 square-root steps; a flat window skips both, and a clipping z skips the root search.
// A new item is taken only in idle, after the last one has finished; a waiting result holds the finish step.
// Reset (rst_n, synchronous, active low) clears sums, the fill counter and the write pointer
// and loads the default thresholds; the ring needs no clear as its output is only used once filled.
module rolling_zscore_band_classifier_core
  import rzs_pkg::*;
#(
  parameter int unsigned WINDOW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // in_tdata: [23:0] price_a, [47:24] price_b
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [47:0]        in_tdata,
  // out_tdata: [0] ready_res, [2:1] signal_class, [22:3] z_value, [23] flat_window
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ThrW-1:0]    cfg_data
);

  localparam int unsigned PtrW  = $clog2(WINDOW);
  localparam int unsigned FillW = $clog2(WINDOW + 1);
  localparam logic signed [7:0] WinS = 8'(WINDOW);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_XSQ  = 4'd1;
  localparam logic [3:0] ST_OSQ  = 4'd2;
  localparam logic [3:0] ST_SSQ  = 4'd3;
  localparam logic [3:0] ST_NSQ  = 4'd4;
  localparam logic [3:0] ST_VAR  = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_SQRT = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0]         state_r;
  logic [FillW-1:0]   fill_r;
  logic [PtrW-1:0]    wp_r;
  logic [SumW-1:0]    sum_r;
  logic [SqSumW-1:0]  sq_r;
  logic [ThrW-1:0]    high_r, inner_r;
  logic [SpreadW-1:0] x_r;
  logic [47:0]        xsq_r, osq_r;
  logic [61:0]        ss_r;
  logic [62:0]        wq_r;
  logic [NumW-1:0]    num_r;
  logic [RemW-1:0]    d_r, rem_r;
  logic [DvdW-1:0]    dvd_r;
  logic [QuoW-1:0]    quo_r;
  logic               sat_r, flat_r;
  logic [ZW-1:0]      k_r;
  logic [6:0]         cnt_r;
  logic               out_valid_r;
  logic [23:0]        out_data_r;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic               full;
  logic               accept;
  logic [SpreadW-1:0] old_x;
  logic [PriceW-1:0]  xmag, omag;
  logic [30:0]        smag;
  logic [31:0]        nmag;
  logic [RemW-1:0]    rem2;
  logic [ZW-1:0]      trial;
  logic               big;
  logic signed [ZW-1:0] z_c;
  logic signed [ZW:0] z_w, hi_w, zabs_w;
  logic [1:0]         cls_c;
  logic               fin_go;

  assign full      = (fill_r == FillW'(WINDOW));
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  rzs_ring #(.Depth(WINDOW)) u_ring (
    .clk     (clk),
    .wr_en   (fin_go),
    .wr_addr (wp_r),
    .wr_data (x_r),
    .rd_en   (accept),
    .rd_addr (wp_r),
    .rd_data (old_x)
  );

  rzs_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  // Magnitudes of the spreads, the window sum and the deviation
  assign xmag  = x_r[SpreadW-1] ? PriceW'(-x_r) : x_r[PriceW-1:0];
  assign omag  = old_x[SpreadW-1] ? PriceW'(-old_x) : old_x[PriceW-1:0];
  assign smag  = sum_r[SumW-1] ? 31'(-sum_r) : sum_r;
  assign nmag  = num_r[NumW-1] ? 32'(-num_r) : num_r[31:0];
  assign rem2  = {rem_r[RemW-2:0], dvd_r[DvdW-1]};
  assign trial = k_r | (ZW'(1) << cnt_r[4:0]);
  assign big   = sat_r | quo_r[QuoW-1];

  // Steer the shared unit by sequencer state
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      ST_XSQ: begin
        alu_req.mul_a = MulW'(xmag);
        alu_req.mul_b = MulW'(xmag);
      end
      ST_OSQ: begin
        alu_req.mul_a = MulW'(omag);
        alu_req.mul_b = MulW'(omag);
      end
      ST_SSQ: begin
        alu_req.mul_a = MulW'(smag);
        alu_req.mul_b = MulW'(smag);
      end
      ST_NSQ: begin
        alu_req.mul_a = nmag;
        alu_req.mul_b = nmag;
      end
      ST_VAR: begin
        alu_req.sub_a = AluW'(wq_r);
        alu_req.sub_b = AluW'(ss_r);
      end
      ST_DIV: begin
        alu_req.sub_a = AluW'(rem2);
        alu_req.sub_b = AluW'(d_r);
      end
      ST_SQRT: begin
        alu_req.mul_a = MulW'(trial);
        alu_req.mul_b = MulW'(trial);
        alu_req.sub_a = AluW'(quo_r);
        alu_req.sub_b = alu_rsp.prod;
      end
      default: alu_req = '0;
    endcase
  end

  // Final z: saturate by sign when flat (zero for a zero deviation), else sign the root and clip; then classify
  always_comb begin
    if (flat_r) begin
      if (num_r == '0) begin
        z_c = '0;
      end else if (num_r[NumW-1]) begin
        z_c = ZMin;
      end else begin
        z_c = ZMax;
      end
    end else if (num_r[NumW-1]) begin
      z_c = ZW'(-k_r);
    end else begin
      z_c = (k_r == KCap) ? ZMax : k_r;
    end
    z_w    = (ZW+1)'(z_c);
    hi_w   = (ZW+1)'({1'b0, high_r});
    zabs_w = z_w[ZW] ? -z_w : z_w;
    if (z_w > hi_w) begin
      cls_c = ClsHigh;
    end else if (z_w < -hi_w) begin
      cls_c = ClsLow;
    end else if (zabs_w < (ZW+1)'({1'b0, inner_r})) begin
      cls_c = ClsInside;
    end else begin
      cls_c = ClsMid;
    end
  end

  // Configuration writes; other indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r  <= HighReset;
      inner_r <= InnerReset;
    end else if (cfg_valid) begin
      if (cfg_index == RegHigh) begin
        high_r <= cfg_data;
      end else if (cfg_index == RegInner) begin
        inner_r <= cfg_data;
      end
    end
  end

  // Result register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data_r <= full ? {flat_r, z_c, cls_c, 1'b1} : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sequencer and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      wp_r    <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            x_r     <= SpreadW'({1'b0, in_tdata[23:0]}) - SpreadW'({1'b0, in_tdata[47:24]});
            state_r <= ST_XSQ;
          end
        end
        ST_XSQ: begin
          xsq_r   <= alu_rsp.prod[47:0];
          state_r <= full ? ST_OSQ : ST_FIN;
        end
        ST_OSQ: begin
          osq_r   <= alu_rsp.prod[47:0];
          num_r   <= (NumW'(signed'(x_r)) * NumW'(WinS)) - NumW'(signed'(sum_r));
          state_r <= ST_SSQ;
        end
        ST_SSQ: begin
          ss_r    <= alu_rsp.prod[61:0];
          wq_r    <= 63'(sq_r) * 63'(WINDOW);
          state_r <= ST_NSQ;
        end
        ST_NSQ: begin
          dvd_r   <= {alu_rsp.prod[RemW-1:0], FracBits'(0)};
          state_r <= ST_VAR;
        end
        ST_VAR: begin
          rem_r <= '0;
          quo_r <= '0;
          sat_r <= 1'b0;
          k_r   <= '0;
          cnt_r <= '0;
          d_r   <= alu_rsp.diff[RemW-1:0];
          if (alu_rsp.borrow || alu_rsp.diff == '0) begin
            flat_r  <= 1'b1;
            state_r <= ST_FIN;
          end else begin
            flat_r  <= 1'b0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          // One restoring division step; mark overflow of the quotient
          rem_r <= alu_rsp.borrow ? rem2 : alu_rsp.diff[RemW-1:0];
          quo_r <= {quo_r[QuoW-2:0], !alu_rsp.borrow};
          sat_r <= sat_r | quo_r[QuoW-1];
          dvd_r <= {dvd_r[DvdW-2:0], 1'b0};
          if (cnt_r == 7'(DvdW - 1)) begin
            cnt_r   <= 7'(SqrtTop);
            state_r <= ST_SQRT;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        ST_SQRT: begin
          // Root above the clip: no need to search
          if (big) begin
            k_r     <= KCap;
            state_r <= ST_FIN;
          end else begin
            if (!alu_rsp.borrow) begin
              k_r <= trial;
            end
            if (cnt_r == '0) begin
              state_r <= ST_FIN;
            end else begin
              cnt_r <= cnt_r - 7'd1;
            end
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            if (full) begin
              sum_r <= sum_r + SumW'(signed'(x_r)) - SumW'(signed'(old_x));
              sq_r  <= sq_r + SqSumW'(xsq_r) - SqSumW'(osq_r);
            end else begin
              sum_r  <= sum_r + SumW'(signed'(x_r));
              sq_r   <= sq_r + SqSumW'(xsq_r);
              fill_r <= fill_r + FillW'(1);
            end
            wp_r    <= (wp_r == PtrW'(WINDOW - 1)) ? '0 : wp_r + PtrW'(1);
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
